// ===== design/internet_checksum_pseudo_header_unit_defines.svh =====
// Assertion helpers shared by the checksum unit.
// Each macro expects clk and rst_n in scope.
`ifndef INTERNET_CHECKSUM_PSEUDO_HEADER_UNIT_DEFINES_SVH
`define INTERNET_CHECKSUM_PSEUDO_HEADER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ICHK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ICHK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ichk_pkg.sv =====
package ichk_pkg;

    localparam logic       KIND_START = 1'b0;
    localparam logic       KIND_DATA  = 1'b1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic
    {
        OP_ACCUM = 1'b0,
        OP_LOAD  = 1'b1
    } cmd_op_t;

    typedef struct packed
    {
        logic        kind;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol;
        logic [7:0]  data_byte;
        logic        last;
    } in_item_t;

    typedef struct packed
    {
        logic [15:0] checksum;
        logic [15:0] payload_length;
    } out_item_t;

    // front -> back command
    typedef struct packed
    {
        cmd_op_t     op;
        logic        last;
        logic [15:0] addend;
        logic [15:0] length;
    } cmd_t;

    // ones'-complement add with end-around carry
    function automatic logic [15:0] add_end_around(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            add_end_around = s[15:0] + {15'd0, s[16]};
        end
    endfunction

endpackage

// ===== design/ichk_fifo.sv =====
module ichk_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    `include "internet_checksum_pseudo_header_unit_defines.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    `ICHK_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= DEPTH_CNT, "fifo count over depth")
    `ICHK_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_reg == $past(count_reg) + CW'(1),
        "fifo count missed a push")
    `ICHK_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_reg == $past(count_reg) - CW'(1),
        "fifo count missed a pop")

endmodule

// ===== design/ichk_front.sv =====
module ichk_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ichk_pkg::in_item_t item,
    output ichk_pkg::cmd_t    cmd
);
    import ichk_pkg::*;

    logic [7:0]  held_reg, held_next;
    logic        pending_reg, pending_next;
    logic [15:0] count_reg, count_next;
    logic        pseudo_reg, pseudo_next;

    logic        is_pseudo;
    logic [18:0] hdr_sum;
    logic [16:0] hdr_fold;
    logic [15:0] hdr_word;
    logic [15:0] cnt_inc;
    logic [15:0] data_word;
    logic [15:0] len_term;

    always_comb
    begin
        is_pseudo = (item.protocol == PROTO_TCP) || (item.protocol == PROTO_UDP);
        hdr_sum   = 19'(item.src_addr[31:16]) + 19'(item.src_addr[15:0])
                  + 19'(item.dst_addr[31:16]) + 19'(item.dst_addr[15:0])
                  + 19'(item.protocol);
        hdr_fold  = 17'(hdr_sum[15:0]) + 17'(hdr_sum[18:16]);
        hdr_word  = hdr_fold[15:0] + 16'(hdr_fold[16]);

        cnt_inc = count_reg + 16'd1;
        // completed pair, or odd final byte padded low
        if (pending_reg)
        begin
            data_word = {held_reg, item.data_byte};
        end
        else if (item.last)
        begin
            data_word = {item.data_byte, 8'd0};
        end
        else
        begin
            data_word = '0;
        end
        len_term = (pseudo_reg && item.last) ? cnt_inc : '0;

        held_next    = held_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        pseudo_next  = pseudo_reg;
        cmd.last     = item.last;

        unique case (item.kind)
            KIND_START:
            begin
                cmd.op       = OP_LOAD;
                cmd.addend   = is_pseudo ? hdr_word : '0;
                cmd.length   = '0;
                held_next    = '0;
                pending_next = 1'b0;
                count_next   = '0;
                pseudo_next  = is_pseudo;
            end
            KIND_DATA:
            begin
                cmd.op       = OP_ACCUM;
                cmd.addend   = add_end_around(data_word, len_term);
                cmd.length   = cnt_inc;
                held_next    = item.data_byte;
                pending_next = !pending_reg;
                count_next   = cnt_inc;
            end
            default:
            begin
                cmd.op     = OP_ACCUM;
                cmd.addend = '0;
                cmd.length = '0;
            end
        endcase

        if (item.last)
        begin
            held_next    = '0;
            pending_next = 1'b0;
            count_next   = '0;
            pseudo_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            pending_reg <= 1'b0;
            count_reg   <= '0;
            pseudo_reg  <= 1'b0;
        end
        else if (accept)
        begin
            held_reg    <= held_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
            pseudo_reg  <= pseudo_next;
        end
    end

endmodule

// ===== design/ichk_back.sv =====
module ichk_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ichk_pkg::cmd_t      cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    input  logic                res_full,
    output logic                res_push,
    output ichk_pkg::out_item_t res
);
    import ichk_pkg::*;

    logic [15:0] sum_reg, sum_next;
    logic [15:0] base;
    logic [15:0] total;

    always_comb
    begin
        cmd_pop  = !cmd_empty && (!cmd.last || !res_full);
        res_push = cmd_pop && cmd.last;

        unique case (cmd.op)
            OP_LOAD:  base = '0;
            OP_ACCUM: base = sum_reg;
            default:  base = sum_reg;
        endcase
        total = add_end_around(base, cmd.addend);

        res.checksum       = ~total;
        res.payload_length = cmd.length;

        sum_next = sum_reg;
        if (cmd_pop)
        begin
            sum_next = cmd.last ? '0 : total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

// ===== design/internet_checksum_pseudo_header_unit.sv =====
// Channel   Handshake             Payload                 Transfer when
// ------    --------------------  ----------------------  -----------------
// input     push / full           in_item  (in_item_t)    push && !full
// result    empty / pop           out_item (out_item_t)   pop && !empty
//
// One item per cycle sustained while the result queue has room for last items:
// one end-around add per item in the back end. A last item's result reaches
// out_item via both queues. Reset (rst_n, async, active low) clears all
// control state and the running sum. full rises only when the command queue
// backs up; a result stall blocks the back end only at a last-flagged command.
module internet_checksum_pseudo_header_unit #(
    parameter int CMD_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  ichk_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output ichk_pkg::out_item_t out_item
);
    import ichk_pkg::*;

    // front end: pairs bytes, counts length, folds the pseudo-header into
    // one addend per item
    logic      accept;
    cmd_t      front_cmd;

    // command queue between front and back
    cmd_t      back_cmd;
    logic      cmd_empty;
    logic      cmd_pop;

    // back end: running sum, result on last
    logic      res_full;
    logic      res_push;
    out_item_t back_res;

    assign accept = push && !full;

    ichk_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_item),
        .cmd    (front_cmd)
    );

    ichk_fifo #(
        .DEPTH (CMD_DEPTH),
        .WIDTH ($bits(cmd_t))
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .dout  (back_cmd),
        .empty (cmd_empty)
    );

    ichk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    // result queue doubles as the output register
    ichk_fifo #(
        .DEPTH (RES_DEPTH),
        .WIDTH ($bits(out_item_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (back_res),
        .full  (res_full),
        .pop   (pop),
        .dout  (out_item),
        .empty (empty)
    );

endmodule
